>>> hdl/rrr_pkg.sv
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared constants and types for the rounded rational rescale core.
// ----------------------------------------------------------------------------
`default_nettype none

package rrr_pkg;

    localparam int VALUE_BITS_DEF      = 32;
    localparam int COVERAGE_LEVELS_DEF = 4;
    localparam int QUOT_BITS           = 8;
    localparam int FIFO_DEPTH          = 4;

    localparam logic       CMD_RESCALE  = 1'b0;
    localparam logic       CMD_COVERAGE = 1'b1;

    localparam logic [1:0] MODE_NEAREST      = 2'd0;
    localparam logic [1:0] MODE_AT_LEAST_ONE = 2'd1;
    localparam logic [1:0] MODE_CEIL         = 2'd2;
    localparam logic [1:0] MODE_UNUSED       = 2'd3;

    typedef struct packed {
        logic bad;
        logic raise;
    } flags_t;

endpackage

`default_nettype wire

>>> hdl/rrr_front.sv
// ----------------------------------------------------------------------------
// rrr_front
// Accepts items, classifies them and forms dividend and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_front #(
    parameter int VALUE_BITS      = rrr_pkg::VALUE_BITS_DEF,
    parameter int COVERAGE_LEVELS = rrr_pkg::COVERAGE_LEVELS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [71:0]             s_tdata,
    input  wire logic [2:0]              s_tuser,
    output logic                         f_valid,
    input  wire logic                    f_ready,
    output rrr_pkg::flags_t              f_flags,
    output logic [VALUE_BITS+9:0]        f_num,
    output logic [VALUE_BITS:0]          f_den
);

    localparam int NW = VALUE_BITS + 10;

    logic [VALUE_BITS-1:0] num;
    logic [VALUE_BITS-1:0] den;
    logic [7:0]            top;
    logic                  cmd;
    logic [1:0]            mode;
    logic                  ceil_mode;
    logic [7:0]            tgt;
    logic [8:0]            mult;
    logic [VALUE_BITS+8:0] prod;
    logic [VALUE_BITS-1:0] addend;
    rrr_pkg::flags_t       flags;
    logic [NW-1:0]         num_calc;
    logic [VALUE_BITS:0]   den_calc;

    logic                  valid_reg;
    rrr_pkg::flags_t       flags_reg;
    logic [NW-1:0]         num_reg;
    logic [VALUE_BITS:0]   den_reg;

    always_comb begin
        num       = s_tdata[VALUE_BITS-1:0];
        den       = s_tdata[32 +: VALUE_BITS];
        top       = s_tdata[71:64];
        cmd       = s_tuser[0];
        mode      = s_tuser[2:1];
        ceil_mode = (cmd == rrr_pkg::CMD_COVERAGE) && (mode == rrr_pkg::MODE_CEIL);
        tgt       = (cmd == rrr_pkg::CMD_COVERAGE) ? 8'(COVERAGE_LEVELS) : top;
        mult      = ceil_mode ? {1'b0, tgt} : {tgt, 1'b0};
        prod      = (VALUE_BITS+9)'(num) * (VALUE_BITS+9)'(mult);
        addend    = ceil_mode ? (den - VALUE_BITS'(1)) : den;
        num_calc  = NW'(prod) + NW'(addend);
        den_calc  = ceil_mode ? {1'b0, den} : {den, 1'b0};
        flags.bad = (den == '0) || (num > den)
                  || ((cmd == rrr_pkg::CMD_RESCALE) && (top == 8'd0))
                  || ((cmd == rrr_pkg::CMD_COVERAGE) && (mode == rrr_pkg::MODE_UNUSED));
        flags.raise = (cmd == rrr_pkg::CMD_COVERAGE) && (mode == rrr_pkg::MODE_AT_LEAST_ONE)
                    && (num != '0);
    end

    assign s_tready = !valid_reg || f_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            flags_reg <= flags;
            num_reg   <= num_calc;
            den_reg   <= den_calc;
        end
    end

    assign f_valid = valid_reg;
    assign f_flags = flags_reg;
    assign f_num   = num_reg;
    assign f_den   = den_reg;

endmodule

`default_nettype wire

>>> hdl/rrr_fifo.sv
// ----------------------------------------------------------------------------
// rrr_fifo
// Short queue between the front and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = rrr_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/rrr_divider.sv
// ----------------------------------------------------------------------------
// rrr_divider
// Restoring divider, one quotient bit per stage, with final result fixup.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_divider #(
    parameter int VALUE_BITS = rrr_pkg::VALUE_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire rrr_pkg::flags_t         in_flags,
    input  wire logic [VALUE_BITS+9:0]   in_num,
    input  wire logic [VALUE_BITS:0]     in_den,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [7:0]                   m_tdata,
    output logic                         m_tuser
);

    localparam int NW = VALUE_BITS + 10;
    localparam int QB = rrr_pkg::QUOT_BITS;

    logic                  v_reg  [QB];
    rrr_pkg::flags_t       fl_reg [QB];
    logic [NW-1:0]         r_reg  [QB];
    logic [VALUE_BITS:0]   d_reg  [QB];
    logic [QB-1:0]         q_reg  [QB];
    logic                  advance;
    logic [QB-1:0]         q_last;

    assign advance  = !v_reg[QB-1] || m_tready;
    assign in_ready = advance;

    for (genvar i = 0; i < QB; i++) begin : g_stage
        logic                v_prev;
        rrr_pkg::flags_t     fl_prev;
        logic [NW-1:0]       r_prev;
        logic [VALUE_BITS:0] d_prev;
        logic [QB-1:0]       q_prev;
        logic [NW-1:0]       trial;
        logic                ge;

        if (i == 0) begin : g_first
            assign v_prev  = in_valid;
            assign fl_prev = in_flags;
            assign r_prev  = in_num;
            assign d_prev  = in_den;
            assign q_prev  = '0;
        end else begin : g_next
            assign v_prev  = v_reg[i-1];
            assign fl_prev = fl_reg[i-1];
            assign r_prev  = r_reg[i-1];
            assign d_prev  = d_reg[i-1];
            assign q_prev  = q_reg[i-1];
        end

        assign trial = NW'(d_prev) << (QB - 1 - i);
        assign ge    = (r_prev >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (advance) begin
                v_reg[i] <= v_prev;
            end
            if (advance) begin
                fl_reg[i] <= fl_prev;
                r_reg[i]  <= ge ? (r_prev - trial) : r_prev;
                d_reg[i]  <= d_prev;
                q_reg[i]  <= {q_prev[QB-2:0], ge};
            end
        end
    end

    assign q_last   = q_reg[QB-1];
    assign m_tvalid = v_reg[QB-1];
    assign m_tuser  = fl_reg[QB-1].bad;

    always_comb begin
        if (fl_reg[QB-1].bad) begin
            m_tdata = 8'd0;
        end else if (fl_reg[QB-1].raise && (q_last == '0)) begin
            m_tdata = 8'd1;
        end else begin
            m_tdata = 8'(q_last);
        end
    end

endmodule

`default_nettype wire

>>> hdl/rounded_rational_rescale_core.sv
// ----------------------------------------------------------------------------
// rounded_rational_rescale_core
// Maps value/denominator onto 0..target_max (rescale) or onto
// 0..COVERAGE_LEVELS (coverage) with round-half-up, round-up-to-one or
// ceiling, flagging a zero denominator, a value above the denominator, a zero
// target_max and the unused coverage mode. One item per cycle is accepted
// while the output is taken; each result passes through one front register,
// one queue entry and eight restoring divider stages that each produce one
// quotient bit. A four-entry queue lets the front keep accepting while the
// result side is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rounded_rational_rescale_core #(
    parameter int VALUE_BITS      = rrr_pkg::VALUE_BITS_DEF,
    parameter int COVERAGE_LEVELS = rrr_pkg::COVERAGE_LEVELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // value[31:0], denominator[63:32], target_max[71:64]
    input  wire logic [2:0]  s_tuser,   // cmd[0], coverage_mode[2:1]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // result[7:0]
    output logic             m_tuser    // error[0]
);

    localparam int NW = VALUE_BITS + 10;
    localparam int DW = VALUE_BITS + 1;
    localparam int QW = 2 + NW + DW;

    logic            f_valid;
    logic            f_ready;
    rrr_pkg::flags_t f_flags;
    logic [NW-1:0]   f_num;
    logic [DW-1:0]   f_den;
    logic            q_valid;
    logic            q_ready;
    logic [QW-1:0]   q_data;
    rrr_pkg::flags_t q_flags;

    rrr_front #(
        .VALUE_BITS      (VALUE_BITS),
        .COVERAGE_LEVELS (COVERAGE_LEVELS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_flags  (f_flags),
        .f_num    (f_num),
        .f_den    (f_den)
    );

    rrr_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_flags, f_num, f_den}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_flags = q_data[QW-1 -: 2];

    rrr_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_flags (q_flags),
        .in_num   (q_data[DW +: NW]),
        .in_den   (q_data[DW-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> dv/rrr_checker.sv
// ----------------------------------------------------------------------------
// rrr_checker
// Watches both streams of the rescale core, predicts each result from the
// accepted input transfer and compares result and error flag in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rrr_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tuser,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] level;
        logic       err;
    } scaled_t;

    scaled_t scaled_q[$];

    function automatic scaled_t project(logic cmd, logic [31:0] num, logic [31:0] den,
                                        logic [7:0] top, logic [1:0] mode);
        scaled_t     r;
        logic [63:0] q;
        logic        bad;
        bad = (den == 0) || (num > den);
        q = 0;
        if (cmd == rrr_pkg::CMD_RESCALE) begin
            if (top == 0) bad = 1'b1;
            if (!bad) q = (64'd2 * num * top + den) / (64'd2 * den);
        end else begin
            if (mode == rrr_pkg::MODE_UNUSED) bad = 1'b1;
            if (!bad) begin
                if (mode == rrr_pkg::MODE_CEIL) begin
                    q = (64'(rrr_pkg::COVERAGE_LEVELS_DEF) * num + den - 64'd1) / den;
                end else begin
                    q = (64'd2 * num * rrr_pkg::COVERAGE_LEVELS_DEF + den) / (64'd2 * den);
                    if (mode == rrr_pkg::MODE_AT_LEAST_ONE && num != 0 && q == 0) q = 1;
                end
            end
        end
        r.level = bad ? 8'd0 : q[7:0];
        r.err = bad;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        scaled_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                scaled_q.push_back(project(s_tuser[0], s_tdata[31:0], s_tdata[63:32],
                                           s_tdata[71:64], s_tuser[2:1]));
            if (m_tvalid && m_tready) begin
                if (scaled_q.size() == 0) begin
                    $error("unexpected result transfer: result %0d error %0b",
                           m_tdata, m_tuser);
                    fail_count = fail_count + 1;
                end else begin
                    e = scaled_q.pop_front();
                    if (m_tdata !== e.level) begin
                        $error("result: expected %0d actual %0d", e.level, m_tdata);
                        fail_count = fail_count + 1;
                    end
                    if (m_tuser !== e.err) begin
                        $error("error: expected %0b actual %0b", e.err, m_tuser);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending = scaled_q.size();
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed corner items and random rescale and coverage requests into
// the rescale core under varying idle patterns and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // value[31:0], denominator[63:32], target_max[71:64]
    logic [2:0]  s_tuser;   // cmd[0], coverage_mode[2:1]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // result[7:0]
    logic        m_tuser;   // error[0]
    int          fail_count;
    int          pending;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          hold_off;
    int          quiet_cycles;

    localparam int QUIET_LIMIT = 2000;

    rounded_rational_rescale_core dut (.*);

    rrr_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(logic cmd, logic [31:0] num, logic [31:0] den,
                             logic [7:0] top, logic [1:0] mode);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {top, den, num};
        s_tuser <= {mode, cmd};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random();
        logic [31:0] den;
        logic [31:0] num;
        int          sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2: den = $urandom;
            3, 4, 5: den = $urandom_range(16);
            default: den = $urandom_range(1000);
        endcase
        if ($urandom_range(9) == 0) num = $urandom;
        else num = (den == 0) ? 0 : $urandom_range(den);
        send_item(1'($urandom_range(1)), num, den,
                  ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom),
                  ($urandom_range(9) == 0) ? rrr_pkg::MODE_UNUSED
                                           : 2'($urandom_range(2)));
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        hold_off = 0;
        quiet_cycles = 0;
        src_idle_pct = 7;
        snk_idle_pct = 60;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_item(rrr_pkg::CMD_RESCALE, 0, 1, 255, rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_RESCALE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255,
                  rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_RESCALE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 255,
                  rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_RESCALE, 1, 2, 1, rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_RESCALE, 1, 3, 1, rrr_pkg::MODE_CEIL);
        send_item(rrr_pkg::CMD_RESCALE, 5, 0, 10, rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_RESCALE, 6, 5, 10, rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_RESCALE, 3, 5, 0, rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_COVERAGE, 1, 8, 0, rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_COVERAGE, 1, 9, 0, rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_COVERAGE, 1, 32'hFFFF_FFFF, 0, rrr_pkg::MODE_AT_LEAST_ONE);
        send_item(rrr_pkg::CMD_COVERAGE, 0, 32'hFFFF_FFFF, 0, rrr_pkg::MODE_AT_LEAST_ONE);
        send_item(rrr_pkg::CMD_COVERAGE, 1, 32'hFFFF_FFFF, 0, rrr_pkg::MODE_CEIL);
        send_item(rrr_pkg::CMD_COVERAGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                  rrr_pkg::MODE_CEIL);
        send_item(rrr_pkg::CMD_COVERAGE, 0, 7, 0, rrr_pkg::MODE_CEIL);
        send_item(rrr_pkg::CMD_COVERAGE, 0, 0, 0, rrr_pkg::MODE_CEIL);
        send_item(rrr_pkg::CMD_COVERAGE, 8, 7, 0, rrr_pkg::MODE_NEAREST);
        send_item(rrr_pkg::CMD_COVERAGE, 3, 7, 0, rrr_pkg::MODE_UNUSED);
        send_item(rrr_pkg::CMD_COVERAGE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 0,
                  rrr_pkg::MODE_NEAREST);

        for (int i = 0; i < 200; i++) send_random();
        src_idle_pct = 60;
        snk_idle_pct = 7;
        for (int i = 0; i < 200; i++) send_random();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_off = 60;
        for (int i = 0; i < 200; i++) send_random();
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
